[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define DAM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted
`define DAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/dam_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dam_pkg
// Types and constants of the decimal accumulator machine.
// ---------------------------------------------------------------------------
package dam_pkg;

    localparam int ADDR_W = 7;
    localparam int WORD_W = 32;

    // actions
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HALTED    = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd2;
    localparam logic [2:0] ST_BAD_WORD  = 3'd3;
    localparam logic [2:0] ST_PC_OVF    = 3'd4;
    localparam logic [2:0] ST_STOPPED   = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_CHAR  = 2'd2;
    localparam logic [1:0] KIND_PEEK  = 2'd3;

    // opcodes
    localparam logic [6:0] OP_READ  = 7'd10;
    localparam logic [6:0] OP_WRITE = 7'd11;
    localparam logic [6:0] OP_PRINT = 7'd12;
    localparam logic [6:0] OP_LOAD  = 7'd20;
    localparam logic [6:0] OP_STORE = 7'd21;
    localparam logic [6:0] OP_ADD   = 7'd30;
    localparam logic [6:0] OP_SUB   = 7'd31;
    localparam logic [6:0] OP_DIV   = 7'd32;
    localparam logic [6:0] OP_MUL   = 7'd33;
    localparam logic [6:0] OP_MOD   = 7'd34;
    localparam logic [6:0] OP_BR    = 7'd40;
    localparam logic [6:0] OP_BRNEG = 7'd41;
    localparam logic [6:0] OP_BRZERO = 7'd42;
    localparam logic [6:0] OP_HALT  = 7'd99;

    localparam logic [31:0] WORD_MAX  = 32'd9999;
    localparam logic [7:0]  NEWLINE   = 8'd10;
    localparam logic [12:0] RECIP_100 = 13'd5243;   // 2^19 / 100, rounded up
    localparam int          RECIP_SH  = 19;

    typedef struct packed {
        logic [1:0]         action;
        logic [6:0]         address;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [1:0]         out_kind;
        logic signed [31:0] out_value;
        logic signed [31:0] accumulator_now;
        logic [6:0]         counter_now;
        logic               last;
    } out_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  kind;
        logic [31:0] value;
        logic        last;
    } pend_t;

    typedef struct packed {
        logic        we;
        logic [6:0]  waddr;
        logic [31:0] wdata;
        logic        re;
        logic [6:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic [6:0] opcode;
        logic [6:0] operand;
    } decode_t;

    // split a word of at most 9999 into word/100 and word%100
    function automatic decode_t split_word(input logic [13:0] w);
        logic [26:0] prod;
        logic [6:0]  q;
        logic [13:0] qx100;
        decode_t     d;
        prod = 27'(w) * 27'(RECIP_100);
        q = prod[RECIP_SH +: 7];
        qx100 = 14'(q) * 14'd100;
        d.opcode = q;
        d.operand = 7'(w - qx100);
        return d;
    endfunction

endpackage

[hdl/dam_mem.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dam_mem
// Word store: one write and one read port, registered read data, per-entry
// valid bits so that never-written words read as zero after reset.
// ---------------------------------------------------------------------------
module dam_mem #(
    parameter int MEM_WORDS = 100
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dam_pkg::mem_req_t  req,
    output logic [31:0]        rdata
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [31:0]          mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] valid_reg;
    logic [31:0]          rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.we)
        begin
            valid_reg[req.waddr[AW-1:0]] <= 1'b1;
        end
    end

    // hold read data between reads
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= valid_reg[req.raddr[AW-1:0]] ? mem[req.raddr[AW-1:0]] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/dam_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dam_div
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating
// toward zero; remainder takes the sign of the dividend.
// ---------------------------------------------------------------------------
module dam_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  count_reg, count_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        qneg_reg, qneg_next;
    logic        rneg_reg, rneg_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        qneg_next  = qneg_reg;
        rneg_next  = rneg_reg;
        shifted    = {rem_reg[31:0], quo_reg[31]};
        diff       = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = dividend[31] ? (~dividend + 32'd1) : dividend;
            dvs_next   = divisor[31] ? (~divisor + 32'd1) : divisor;
            qneg_next  = dividend[31] ^ divisor[31];
            rneg_next  = dividend[31];
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            count_next = count_reg + 5'd1;
            if (count_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = qneg_reg ? (~quo_reg + 32'd1) : quo_reg;
    assign remainder = rneg_reg ? (~rem_reg[31:0] + 32'd1) : rem_reg[31:0];

endmodule

[hdl/decimal_accumulator_machine_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_accumulator_machine_core
// Accumulator machine with a word store, loaded, peeked and stepped per
// transaction.
// ---------------------------------------------------------------------------
// Usage: send transactions on the item channel (valid/ready). Load writes a
// word, peek returns a word, step executes the instruction at the counter.
// Every transaction yields one result transaction on the result channel with
// last set, except print string, which yields one per character plus a
// newline result carrying last.
// Divide and modulo wait for the bit-serial divider; print string makes one
// store read per character.
// Items are taken one at a time; the next is accepted once the previous one
// has placed its last result in the output register.
// Reset clears accumulator, counter and stopped flag; store valid bits make
// every word read as zero until written.
// A stalled receiver holds the output register; the machine waits for it to
// free up before producing the next result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_accumulator_machine_core #(
    parameter int MEM_WORDS        = 100,
    parameter int MAX_STRING_CHARS = 63
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  dam_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_ready,
    output dam_pkg::out_t result
);

    localparam int         CW      = $clog2(MAX_STRING_CHARS + 1);
    localparam logic [6:0] MEM_LIM = 7'(MEM_WORDS);
    localparam logic [CW-1:0] STR_LIM = CW'(MAX_STRING_CHARS);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_PEEK    = 9'b000000010,
        S_FETCH   = 9'b000000100,
        S_OPRD    = 9'b000001000,
        S_EXEC    = 9'b000010000,
        S_DIV     = 9'b000100000,
        S_STR_CHK = 9'b001000000,
        S_STR_RD  = 9'b010000000,
        S_EMIT    = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [31:0]         acc_reg, acc_next;
    logic [6:0]          pc_reg, pc_next;
    logic                stopped_reg, stopped_next;
    dam_pkg::pend_t      pend_reg, pend_next;
    logic                peek_ok_reg, peek_ok_next;
    logic [31:0]         in_val_reg, in_val_next;
    dam_pkg::decode_t    dec_reg, dec_next;
    logic [6:0]          ptr_reg, ptr_next;
    logic                ptr_ok_reg, ptr_ok_next;
    logic [CW-1:0]       nchar_reg, nchar_next;
    logic                result_valid_reg, result_valid_next;
    dam_pkg::out_t       result_reg, result_next;

    dam_pkg::mem_req_t   mreq;
    logic [31:0]         rdata;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [31:0]         div_quo;
    logic [31:0]         div_rem;
    logic [31:0]         str_word;

    dam_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rdata (rdata)
    );

    dam_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (acc_reg),
        .divisor   (rdata),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    function automatic dam_pkg::pend_t mk(input logic [2:0] st, input logic [1:0] kd,
                                          input logic [31:0] v, input logic lst);
        dam_pkg::pend_t p;
        p.status = st;
        p.kind   = kd;
        p.value  = v;
        p.last   = lst;
        return p;
    endfunction

    assign str_word = ptr_ok_reg ? rdata : '0;

    always_comb
    begin
        state_next        = state_reg;
        acc_next          = acc_reg;
        pc_next           = pc_reg;
        stopped_next      = stopped_reg;
        pend_next         = pend_reg;
        peek_ok_next      = peek_ok_reg;
        in_val_next       = in_val_reg;
        dec_next          = dec_reg;
        ptr_next          = ptr_reg;
        ptr_ok_next       = ptr_ok_reg;
        nchar_next        = nchar_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg & ~result_ready;
        mreq              = '0;
        div_start         = 1'b0;
        item_ready        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    unique case (item.action)
                        dam_pkg::ACT_LOAD:
                        begin
                            mreq.we    = (item.address < MEM_LIM);
                            mreq.waddr = item.address;
                            mreq.wdata = item.value;
                            pend_next  = mk(dam_pkg::ST_OK, dam_pkg::KIND_NONE, '0, 1'b1);
                            state_next = S_EMIT;
                        end
                        dam_pkg::ACT_PEEK:
                        begin
                            mreq.re      = (item.address < MEM_LIM);
                            mreq.raddr   = item.address;
                            peek_ok_next = (item.address < MEM_LIM);
                            state_next   = S_PEEK;
                        end
                        dam_pkg::ACT_STEP:
                        begin
                            in_val_next = item.value;
                            if (stopped_reg)
                            begin
                                pend_next  = mk(dam_pkg::ST_STOPPED, dam_pkg::KIND_NONE,
                                                '0, 1'b1);
                                state_next = S_EMIT;
                            end
                            else if (pc_reg >= MEM_LIM)
                            begin
                                stopped_next = 1'b1;
                                pend_next    = mk(dam_pkg::ST_PC_OVF, dam_pkg::KIND_NONE,
                                                  '0, 1'b1);
                                state_next   = S_EMIT;
                            end
                            else
                            begin
                                mreq.re    = 1'b1;
                                mreq.raddr = pc_reg;
                                state_next = S_FETCH;
                            end
                        end
                        dam_pkg::ACT_NONE:
                        begin
                            pend_next  = mk(dam_pkg::ST_OK, dam_pkg::KIND_NONE, '0, 1'b1);
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_PEEK:
            begin
                pend_next  = mk(dam_pkg::ST_OK, dam_pkg::KIND_PEEK,
                                peek_ok_reg ? rdata : '0, 1'b1);
                state_next = S_EMIT;
            end

            S_FETCH:
            begin
                // split opcode and operand; reject anything above four digits
                dec_next = dam_pkg::split_word(rdata[13:0]);
                if (rdata > dam_pkg::WORD_MAX)
                begin
                    stopped_next = 1'b1;
                    pend_next    = mk(dam_pkg::ST_BAD_WORD, dam_pkg::KIND_NONE, '0, 1'b1);
                    state_next   = S_EMIT;
                end
                else
                begin
                    state_next = S_OPRD;
                end
            end

            S_OPRD:
            begin
                if (dec_reg.operand >= MEM_LIM)
                begin
                    stopped_next = 1'b1;
                    pend_next    = mk(dam_pkg::ST_BAD_WORD, dam_pkg::KIND_NONE, '0, 1'b1);
                    state_next   = S_EMIT;
                end
                else
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = dec_reg.operand;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                pend_next  = mk(dam_pkg::ST_OK, dam_pkg::KIND_NONE, '0, 1'b1);
                state_next = S_EMIT;
                pc_next    = pc_reg + 7'd1;
                unique case (dec_reg.opcode)
                    dam_pkg::OP_READ:
                    begin
                        mreq.we    = 1'b1;
                        mreq.waddr = dec_reg.operand;
                        mreq.wdata = in_val_reg;
                    end
                    dam_pkg::OP_WRITE:
                    begin
                        pend_next = mk(dam_pkg::ST_OK, dam_pkg::KIND_WRITE, rdata, 1'b1);
                    end
                    dam_pkg::OP_PRINT:
                    begin
                        ptr_next    = dec_reg.operand;
                        ptr_ok_next = 1'b1;
                        nchar_next  = '0;
                        state_next  = S_STR_CHK;
                    end
                    dam_pkg::OP_LOAD:  acc_next = rdata;
                    dam_pkg::OP_STORE:
                    begin
                        mreq.we    = 1'b1;
                        mreq.waddr = dec_reg.operand;
                        mreq.wdata = acc_reg;
                    end
                    dam_pkg::OP_ADD:   acc_next = acc_reg + rdata;
                    dam_pkg::OP_SUB:   acc_next = acc_reg - rdata;
                    dam_pkg::OP_MUL:   acc_next = acc_reg * rdata;
                    dam_pkg::OP_DIV, dam_pkg::OP_MOD:
                    begin
                        pc_next = pc_reg;
                        if (rdata == '0)
                        begin
                            stopped_next = 1'b1;
                            pend_next    = mk(dam_pkg::ST_DIV_ZERO, dam_pkg::KIND_NONE,
                                              '0, 1'b1);
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    dam_pkg::OP_BR:    pc_next = dec_reg.operand;
                    dam_pkg::OP_BRNEG:
                    begin
                        if (acc_reg[31])
                        begin
                            pc_next = dec_reg.operand;
                        end
                    end
                    dam_pkg::OP_BRZERO:
                    begin
                        if (acc_reg == '0)
                        begin
                            pc_next = dec_reg.operand;
                        end
                    end
                    dam_pkg::OP_HALT:
                    begin
                        stopped_next = 1'b1;
                        pend_next    = mk(dam_pkg::ST_HALTED, dam_pkg::KIND_NONE, '0, 1'b1);
                    end
                    default:
                    begin
                        pc_next      = pc_reg;
                        stopped_next = 1'b1;
                        pend_next    = mk(dam_pkg::ST_BAD_WORD, dam_pkg::KIND_NONE, '0, 1'b1);
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    acc_next   = (dec_reg.opcode == dam_pkg::OP_MOD) ? div_rem : div_quo;
                    pc_next    = pc_reg + 7'd1;
                    pend_next  = mk(dam_pkg::ST_OK, dam_pkg::KIND_NONE, '0, 1'b1);
                    state_next = S_EMIT;
                end
            end

            S_STR_CHK:
            begin
                state_next = S_EMIT;
                if (str_word == '0)
                begin
                    pend_next = mk(dam_pkg::ST_OK, dam_pkg::KIND_CHAR, 32'(dam_pkg::NEWLINE),
                                   1'b1);
                end
                else if (nchar_reg >= STR_LIM)
                begin
                    pend_next = mk(dam_pkg::ST_TRUNCATED, dam_pkg::KIND_CHAR,
                                   32'(dam_pkg::NEWLINE), 1'b1);
                end
                else
                begin
                    pend_next  = mk(dam_pkg::ST_OK, dam_pkg::KIND_CHAR, 32'(str_word[7:0]),
                                    1'b0);
                    nchar_next = nchar_reg + CW'(1);
                    ptr_next   = ptr_reg + 7'd1;
                end
            end

            S_STR_RD:
            begin
                // past the end of the store counts as a terminator
                mreq.re     = (ptr_reg < MEM_LIM);
                mreq.raddr  = ptr_reg;
                ptr_ok_next = (ptr_reg < MEM_LIM);
                state_next  = S_STR_CHK;
            end

            S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next           = 1'b1;
                    result_next.status          = pend_reg.status;
                    result_next.out_kind        = pend_reg.kind;
                    result_next.out_value       = pend_reg.value;
                    result_next.accumulator_now = acc_reg;
                    result_next.counter_now     = pc_reg;
                    result_next.last            = pend_reg.last;
                    state_next = pend_reg.last ? S_IDLE : S_STR_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            acc_reg          <= '0;
            pc_reg           <= '0;
            stopped_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            acc_reg          <= acc_next;
            pc_reg           <= pc_next;
            stopped_reg      <= stopped_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg    <= pend_next;
        peek_ok_reg <= peek_ok_next;
        in_val_reg  <= in_val_next;
        dec_reg     <= dec_next;
        ptr_reg     <= ptr_next;
        ptr_ok_reg  <= ptr_ok_next;
        nchar_reg   <= nchar_next;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // stopped clears only through reset
    `DAM_ASSERT_IMPL(a_stopped_sticky, clk, rst_n, 1'b1, !$fell(stopped_reg))
    // counter never passes one beyond the store
    `DAM_ASSERT_IMPL(a_pc_range, clk, rst_n, 1'b1, pc_reg <= MEM_LIM)
    // divider runs only while the machine waits for it
    `DAM_ASSERT_IMPL(a_div_owned, clk, rst_n, div_busy, state_reg == S_DIV)

endmodule
